### hw/rtl/rdc_pkg.sv
// Shared types, constants and helper functions of the radix digit converter.
// Used by rdc_core and radix_digit_converter; depends on nothing.
`timescale 1ns / 1ps

package rdc_pkg;

    // Magnitude width of an accepted value. A valid value lies in 1 .. 2^VALUE_BITS - 1,
    // and the 32-bit signed field never carries more than 31 magnitude bits.
    localparam int VALUE_BITS = 31;
    localparam int MAG_BITS   = (VALUE_BITS < 31) ? VALUE_BITS : 31;

    // One stored power per digit; the largest count comes with radix 2.
    localparam int MAX_DIGITS = MAG_BITS;
    localparam int IDX_BITS   = $clog2(MAX_DIGITS);

    localparam int RADIX_BITS = 6;
    localparam int DIGIT_BITS = 6;
    localparam int BIT_BITS   = 3;

    // A power times the radix, and a power shifted by up to five places, fit here.
    localparam int PROD_BITS  = MAG_BITS + RADIX_BITS;
    localparam int SUB_BITS   = PROD_BITS + 1;

    localparam logic [RADIX_BITS-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX = 6'd36;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_CHK  = 6'b000100,
        ST_DIG  = 6'b001000,
        ST_EMIT = 6'b010000,
        ST_BAD  = 6'b100000
    } t_state;

    // One result handed from the sequencer to the output register.
    typedef struct packed {
        logic                  valid;
        logic [DIGIT_BITS-1:0] digit;
        logic                  last;
        logic                  invalid;
    } t_emit;

    // Position of the highest set bit of radix - 1, which is the top bit a digit can use.
    function automatic logic [BIT_BITS-1:0] top_bit(input logic [RADIX_BITS-1:0] radix);
        logic [RADIX_BITS-1:0] span;
        logic [BIT_BITS-1:0]   pos;
        span = radix - 6'd1;
        pos  = '0;
        for (int b = 0; b < RADIX_BITS; b++) begin
            if (span[b]) begin
                pos = BIT_BITS'(b);
            end
        end
        return pos;
    endfunction

endpackage

### hw/rtl/radix_digit_converter.sv
// Top level of the radix digit converter: request handshake and output register.
// Depends on rdc_pkg and instantiates rdc_core.
`timescale 1ns / 1ps

// Usage
// The input channel takes one request (i_value, i_radix) when i_valid and o_ready are
// both high. The output channel gives one result per digit (o_digit, o_is_last,
// o_invalid), most significant digit first, when o_valid and i_ready are both high.
// The last digit carries o_is_last. A value below 1 or a radix outside 2 to 36 gives a
// single result with digit 0 and both o_is_last and o_invalid set.
// Timing
// One request is worked on at a time and o_ready stays low until its final result has
// been loaded into the output register. The sequencer first builds the powers of the
// radix, each by a multiply and then a compare on the shared subtractor, and then finds
// each digit by restoring trial subtraction, one digit bit per cycle, and then hands
// the digit over to the output register.
// Reset and stalls
// Synchronous active-low reset returns the sequencer to idle and empties the output
// register. When the receiver holds i_ready low, the result stays in the output
// register and the sequencer waits with the next digit until the register frees up.

module radix_digit_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_value,
    input  logic [5:0]  i_radix,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_digit,
    output logic        o_is_last,
    output logic        o_invalid
);

    logic           w_idle;
    logic           w_start;
    logic           w_slot_free;
    rdc_pkg::t_emit w_emit;

    logic           r_out_valid;
    logic [5:0]     r_digit;
    logic           r_last;
    logic           r_invalid;

    assign o_ready     = w_idle;
    assign w_start     = i_valid && w_idle;

    // The output register can take a new result when empty or when it is drained now.
    assign w_slot_free = !r_out_valid || i_ready;

    rdc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_value     (i_value),
        .i_radix     (i_radix),
        .i_slot_free (w_slot_free),
        .o_idle      (w_idle),
        .o_emit      (w_emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit.valid) begin
            r_digit   <= w_emit.digit;
            r_last    <= w_emit.last;
            r_invalid <= w_emit.invalid;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_digit   = r_digit;
    assign o_is_last = r_last;
    assign o_invalid = r_invalid;

`ifndef SYNTH
    // A result that reports bad input is always the lone, final result with a zero digit.
    a_invalid_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_invalid |-> o_is_last && (o_digit == 6'd0))
        else $error("invalid result without last marker or with nonzero digit");

    // The sequencer never overwrites a result that the receiver has not yet taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_emit.valid && o_valid && !i_ready))
        else $error("output register overwritten while stalled");

    // An accepted request leaves the sequencer busy in the next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !o_ready)
        else $error("sequencer still idle after accepting a request");
`endif

endmodule

### hw/rtl/rdc_pow_table.sv
// Generic memory with one synchronous write port and one registered read port.
// Width and depth are set by its parameters; it depends on no other file.
`timescale 1ns / 1ps

module rdc_pow_table #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/rdc_core.sv
// Sequencer and shared multiply / subtract datapath of the radix digit converter.
// Depends on rdc_pkg and instantiates rdc_pow_table.
`timescale 1ns / 1ps

module rdc_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [31:0]                    i_value,
    input  logic [rdc_pkg::RADIX_BITS-1:0] i_radix,
    input  logic                           i_slot_free,
    output logic                           o_idle,
    output rdc_pkg::t_emit                 o_emit
);

    rdc_pkg::t_state r_state, n_state;

    logic [rdc_pkg::MAG_BITS-1:0]   r_value, n_value;
    logic [rdc_pkg::RADIX_BITS-1:0] r_radix, n_radix;
    logic [rdc_pkg::MAG_BITS-1:0]   r_pow, n_pow;
    logic [rdc_pkg::PROD_BITS-1:0]  r_prod, n_prod;
    logic [rdc_pkg::IDX_BITS-1:0]   r_idx, n_idx;
    logic [rdc_pkg::BIT_BITS-1:0]   r_bit, n_bit;
    logic [rdc_pkg::BIT_BITS-1:0]   r_top, n_top;
    logic [rdc_pkg::MAG_BITS-1:0]   r_rem, n_rem;
    logic [rdc_pkg::DIGIT_BITS-1:0] r_dig, n_dig;

    logic                           w_ok;
    logic                           w_we;
    logic [rdc_pkg::MAG_BITS-1:0]   w_pow;
    logic [rdc_pkg::PROD_BITS-1:0]  w_shift;
    logic [rdc_pkg::SUB_BITS-1:0]   w_sub_a, w_sub_b, w_diff;
    logic                           w_fits;

    // The read address is the next index, so the registered power of the current index is
    // ready for each digit step.
    rdc_pow_table #(
        .WIDTH (rdc_pkg::MAG_BITS),
        .DEPTH (rdc_pkg::MAX_DIGITS)
    ) u_pow_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx),
        .i_wdata (r_pow),
        .i_raddr (n_idx),
        .o_rdata (w_pow)
    );

    // Positive, inside the magnitude range, and a radix from 2 to 36.
    assign w_ok = !i_value[31] && (i_value != 32'd0)
                  && ((i_value[30:0] >> rdc_pkg::MAG_BITS) == 31'd0)
                  && (i_radix >= rdc_pkg::RADIX_MIN) && (i_radix <= rdc_pkg::RADIX_MAX);

    assign w_we    = (r_state == rdc_pkg::ST_MUL);
    assign w_shift = rdc_pkg::PROD_BITS'(w_pow) << r_bit;

    // The one subtractor: power check while building powers, trial subtract per digit bit.
    always_comb begin
        if (r_state == rdc_pkg::ST_CHK) begin
            w_sub_a = rdc_pkg::SUB_BITS'(r_value);
            w_sub_b = rdc_pkg::SUB_BITS'(r_prod);
        end else begin
            w_sub_a = rdc_pkg::SUB_BITS'(r_rem);
            w_sub_b = rdc_pkg::SUB_BITS'(w_shift);
        end
    end

    assign w_diff = w_sub_a - w_sub_b;
    assign w_fits = !w_diff[rdc_pkg::SUB_BITS-1];

    always_comb begin
        n_state = r_state;
        n_value = r_value;
        n_radix = r_radix;
        n_pow   = r_pow;
        n_prod  = r_prod;
        n_idx   = r_idx;
        n_bit   = r_bit;
        n_top   = r_top;
        n_rem   = r_rem;
        n_dig   = r_dig;
        o_emit  = '0;
        case (r_state)
            rdc_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_value = i_value[rdc_pkg::MAG_BITS-1:0];
                    n_radix = i_radix;
                    n_pow   = rdc_pkg::MAG_BITS'(1);
                    n_idx   = '0;
                    n_top   = rdc_pkg::top_bit(i_radix);
                    n_state = w_ok ? rdc_pkg::ST_MUL : rdc_pkg::ST_BAD;
                end
            end
            rdc_pkg::ST_MUL: begin
                n_prod  = rdc_pkg::PROD_BITS'(r_pow) * rdc_pkg::PROD_BITS'(r_radix);
                n_state = rdc_pkg::ST_CHK;
            end
            rdc_pkg::ST_CHK: begin
                if (w_fits) begin
                    n_pow   = r_prod[rdc_pkg::MAG_BITS-1:0];
                    n_idx   = r_idx + 1'b1;
                    n_state = rdc_pkg::ST_MUL;
                end else begin
                    n_rem   = r_value;
                    n_bit   = r_top;
                    n_dig   = '0;
                    n_state = rdc_pkg::ST_DIG;
                end
            end
            rdc_pkg::ST_DIG: begin
                if (w_fits) begin
                    n_rem = w_diff[rdc_pkg::MAG_BITS-1:0];
                    n_dig = r_dig | (rdc_pkg::DIGIT_BITS'(1) << r_bit);
                end
                if (r_bit == '0) begin
                    n_state = rdc_pkg::ST_EMIT;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            rdc_pkg::ST_EMIT: begin
                o_emit.valid   = i_slot_free;
                o_emit.digit   = r_dig;
                o_emit.last    = (r_idx == '0);
                o_emit.invalid = 1'b0;
                if (i_slot_free) begin
                    if (r_idx == '0) begin
                        n_state = rdc_pkg::ST_IDLE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_bit   = r_top;
                        n_dig   = '0;
                        n_state = rdc_pkg::ST_DIG;
                    end
                end
            end
            rdc_pkg::ST_BAD: begin
                o_emit.valid   = i_slot_free;
                o_emit.digit   = '0;
                o_emit.last    = 1'b1;
                o_emit.invalid = 1'b1;
                if (i_slot_free) begin
                    n_state = rdc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rdc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rdc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_radix <= n_radix;
        r_pow   <= n_pow;
        r_prod  <= n_prod;
        r_idx   <= n_idx;
        r_bit   <= n_bit;
        r_top   <= n_top;
        r_rem   <= n_rem;
        r_dig   <= n_dig;
    end

    assign o_idle = (r_state == rdc_pkg::ST_IDLE);

endmodule

### test/radix_digit_converter_test.sv
// Self-checking testbench of radix_digit_converter: directed and random requests, random
// idling on both channels and one long output stall, checked digit by digit in order.
// Depends on rdc_pkg and radix_digit_converter.
`timescale 1ns / 1ps

module radix_digit_converter_test;

    localparam int IDLE_PERCENT   = 22;
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int RANDOM_COUNT   = 380;
    localparam int HOLD_START     = 1500;
    localparam int HOLD_CYCLES    = 400;
    localparam int CALM_FIRST     = 4000;
    localparam int CALM_LAST      = 8000;

    typedef struct {
        logic [31:0] value;
        logic [5:0]  radix;
    } t_request;

    // One expected digit, tagged with the request that produced it.
    typedef struct {
        logic [31:0] value;
        logic [5:0]  radix;
        logic [5:0]  digit;
        logic        last;
        logic        invalid;
    } t_digit;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_value = '0;
    logic [5:0]  i_radix = '0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [5:0]  o_digit;
    logic        o_is_last;
    logic        o_invalid;

    t_request    pending[$];
    t_digit      digits_due[$];
    int unsigned total_requests = 0;
    int unsigned requests_taken = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned hold_left      = 0;
    logic        calm;

    radix_digit_converter i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_value   (i_value),
        .i_radix   (i_radix),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_digit   (o_digit),
        .o_is_last (o_is_last),
        .o_invalid (o_invalid)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Neither side idles inside this window.
    assign calm = (cycle_count >= CALM_FIRST) && (cycle_count < CALM_LAST);

    task automatic note_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic queue_request(input logic [31:0] value, input logic [5:0] radix);
        t_request req;
        req.value = value;
        req.radix = radix;
        pending.push_back(req);
    endtask

    // Expected digits of one request, most significant first, appended to digits_due.
    function automatic void predict_digits(input logic [31:0] value, input logic [5:0] radix);
        longint unsigned rest;
        logic [5:0]      msd_first[$];
        t_digit          entry;
        logic            bad;
        rest = {32'd0, value};
        entry.value = value;
        entry.radix = radix;
        bad = value[31] || (value == 32'd0) || (rest >= (64'd1 << rdc_pkg::VALUE_BITS))
            || (radix < rdc_pkg::RADIX_MIN) || (radix > rdc_pkg::RADIX_MAX);
        if (!bad) begin
            while (rest != 0) begin
                msd_first.push_front(6'(rest % radix));
                rest = rest / radix;
            end
            bad = msd_first.size() > rdc_pkg::MAX_DIGITS;
        end
        if (bad) begin
            entry.digit   = '0;
            entry.last    = 1'b1;
            entry.invalid = 1'b1;
            digits_due.push_back(entry);
        end else begin
            for (int k = 0; k < msd_first.size(); k++) begin
                entry.digit   = msd_first[k];
                entry.last    = (k == msd_first.size() - 1);
                entry.invalid = 1'b0;
                digits_due.push_back(entry);
            end
        end
    endfunction

    // Sender: offers the next pending request, idling at random outside the calm window.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
                i_valid <= 1'b1;
                i_value <= pending[0].value;
                i_radix <= pending[0].radix;
                void'(pending.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off that backs the block up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (cycle_count == HOLD_START) begin
            i_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Monitor: checks each accepted digit against the oldest expectation, then predicts
    // the digits of a request accepted at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (digits_due.size() == 0) begin
                    note_mismatch($sformatf("digit %0d last %0b invalid %0b with none due",
                                            o_digit, o_is_last, o_invalid));
                end else begin
                    if (o_digit !== digits_due[0].digit) begin
                        note_mismatch($sformatf("value %0d radix %0d: digit %0d, want %0d",
                                                $signed(digits_due[0].value),
                                                digits_due[0].radix, o_digit,
                                                digits_due[0].digit));
                    end
                    if (o_is_last !== digits_due[0].last) begin
                        note_mismatch($sformatf("value %0d radix %0d: is_last %0b, want %0b",
                                                $signed(digits_due[0].value),
                                                digits_due[0].radix, o_is_last,
                                                digits_due[0].last));
                    end
                    if (o_invalid !== digits_due[0].invalid) begin
                        note_mismatch($sformatf("value %0d radix %0d: invalid %0b, want %0b",
                                                $signed(digits_due[0].value),
                                                digits_due[0].radix, o_invalid,
                                                digits_due[0].invalid));
                    end
                    void'(digits_due.pop_front());
                end
            end
            if (i_valid && o_ready) begin
                predict_digits(i_value, i_radix);
                requests_taken <= requests_taken + 1;
            end
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned roll;
        int unsigned width;
        logic [31:0] value;
        logic [5:0]  radix;

        // Directed requests: extremes, exact powers and every kind of bad input.
        queue_request(32'd1, 6'd2);
        queue_request(32'd1, 6'd36);
        queue_request(32'h7FFF_FFFF, 6'd2);
        queue_request(32'h7FFF_FFFF, 6'd36);
        queue_request(32'h7FFF_FFFF, 6'd3);
        queue_request(32'h4000_0000, 6'd2);
        queue_request(32'd2, 6'd2);
        queue_request(32'd35, 6'd36);
        queue_request(32'd36, 6'd36);
        queue_request(32'd1295, 6'd36);
        queue_request(32'd46656, 6'd36);
        queue_request(32'd255, 6'd16);
        queue_request(32'd256, 6'd16);
        queue_request(32'd1234567890, 6'd10);
        queue_request(32'd0, 6'd10);
        queue_request(32'hFFFF_FFFF, 6'd10);
        queue_request(32'h8000_0000, 6'd10);
        queue_request(32'd100, 6'd0);
        queue_request(32'd100, 6'd1);
        queue_request(32'd100, 6'd37);
        queue_request(32'd100, 6'd63);
        queue_request(32'd0, 6'd0);

        // Random requests: mostly well-formed with varied magnitudes, some bad input.
        for (int n = 0; n < RANDOM_COUNT; n++) begin
            roll  = $urandom_range(99);
            width = $urandom_range(31, 1);
            value = $urandom & ((32'h1 << width) - 32'h1);
            if (value == 32'd0) begin
                value = 32'd1;
            end
            case ($urandom_range(9))
                0: radix = 6'd2;
                1: radix = 6'd36;
                2: radix = 6'd10;
                3: radix = 6'd16;
                default: radix = 6'($urandom_range(36, 2));
            endcase
            if (roll >= 95) begin
                value = $urandom;
                radix = 6'($urandom);
            end else if (roll >= 88) begin
                radix = ($urandom_range(1) == 0) ? 6'($urandom_range(1))
                                                 : 6'($urandom_range(63, 37));
            end else if (roll >= 80) begin
                value = ($urandom_range(2) == 0) ? 32'd0 : ($urandom | 32'h8000_0000);
                radix = 6'($urandom_range(63));
            end
            queue_request(value, radix);
        end
        total_requests = pending.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_taken != total_requests) @(negedge i_clk);
        while (digits_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
